@@ design/hst_lca_distance_query_macros.svh @@
// assertion macros for the lca distance query block
`ifndef HST_LCA_DISTANCE_QUERY_MACROS_SVH
`define HST_LCA_DISTANCE_QUERY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HLD_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hld check failed");
`define HLD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hld check failed");
`else
`define HLD_ASSERT_IMPL(name, ante, cons)
`define HLD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ design/hld_pkg.sv @@
`default_nettype none
package hld_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int LEVELS_DEF    = 21;
	localparam int ID_BITS_DEF   = 20;

	localparam int NODE_W     = 10;
	localparam int LEVEL_W    = 5;
	localparam int ANC_W      = 20;
	localparam int GAMMA_W    = 24;
	localparam int DIST_W     = 46;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_TREE_HEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA       = 1'd1;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'h800000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIST
	} state_t;

	typedef struct packed {
		logic write;
		logic load;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic out_full;
	} stat_t;

endpackage
`default_nettype wire

@@ design/hld_if.sv @@
`default_nettype none
interface hld_req_if import hld_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [NODE_W-1:0]  node_a;
	logic [NODE_W-1:0]  node_b;
	logic [LEVEL_W-1:0] write_level;
	logic [ANC_W-1:0]   ancestor_id;

	modport source (output valid, kind, node_a, node_b, write_level, ancestor_id, input ready);
	modport sink (input valid, kind, node_a, node_b, write_level, ancestor_id, output ready);
endinterface

interface hld_rsp_if import hld_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] lca_level;
	logic [ANC_W-1:0]   lca_id;
	logic [DIST_W-1:0]  tree_distance;

	modport source (output valid, lca_level, lca_id, tree_distance, input ready);
	modport sink (input valid, lca_level, lca_id, tree_distance, output ready);
endinterface
`default_nettype wire

@@ design/hld_ctrl.sv @@
`default_nettype none
module hld_ctrl import hld_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   req_valid,
	input  wire logic   req_kind,
	output logic        req_ready,
	input  wire stat_t  stat,
	output cmd_t        cmd,
	output state_t      state
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		req_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_kind == KIND_QUERY) begin
						cmd.load   = 1'b1;
						state_next = ST_SCAN;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					state_next = ST_DIST;
				end
			end
			ST_DIST: begin
				if (!stat.out_full) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule
`default_nettype wire

@@ design/hld_dp.sv @@
`default_nettype none
module hld_dp import hld_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int LEVELS    = LEVELS_DEF,
	parameter int ID_BITS   = ID_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	input  wire logic [NODE_W-1:0]     req_node_a,
	input  wire logic [NODE_W-1:0]     req_node_b,
	input  wire logic [LEVEL_W-1:0]    req_write_level,
	input  wire logic [ANC_W-1:0]      req_ancestor_id,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic [LEVEL_W-1:0]         lca_level,
	output logic [ANC_W-1:0]           lca_id,
	output logic [DIST_W-1:0]          tree_distance
);

	localparam int DEPTH  = MAX_NODES * LEVELS;
	localparam int AW     = $clog2(DEPTH);
	localparam int FULL_W = GAMMA_W + 34;

	logic [ID_BITS-1:0] mem [DEPTH];

	logic [LEVEL_W-1:0] th_q;
	logic [GAMMA_W-1:0] gamma_q;
	logic [LEVEL_W-1:0] h;

	logic [AW-1:0]      base_a_q;
	logic [AW-1:0]      base_b_q;
	logic               a_oob_q;
	logic               b_oob_q;
	logic [LEVEL_W:0]   iss_q;
	logic               cmp_v_q;
	logic [LEVEL_W-1:0] cmp_lvl_q;
	logic [ID_BITS-1:0] rd_a_q;
	logic [ID_BITS-1:0] rd_b_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [ANC_W-1:0]   id_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic               iss_ok;
	logic               rd_en;
	logic [AW-1:0]      rd_addr_a;
	logic [AW-1:0]      rd_addr_b;
	logic [ID_BITS-1:0] ea;
	logic [ID_BITS-1:0] eb;
	logic [FULL_W-1:0]  g_full;
	logic [FULL_W-1:0]  dist_full;
	logic [DIST_W-1:0]  dist_sat;

	logic               rsp_valid_q;
	logic [LEVEL_W-1:0] lca_level_q;
	logic [ANC_W-1:0]   lca_id_q;
	logic [DIST_W-1:0]  tree_distance_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_q    <= '0;
			gamma_q <= GAMMA_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TREE_HEIGHT: th_q    <= cfg_data[LEVEL_W-1:0];
				CFG_GAMMA:       gamma_q <= cfg_data[GAMMA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign h = (th_q > LEVEL_W'(LEVELS - 1)) ? LEVEL_W'(LEVELS - 1) : th_q;

	// table write
	assign wr_en = cmd.write && (32'(req_node_a) < 32'(MAX_NODES))
		&& (32'(req_write_level) < 32'(LEVELS));
	assign wr_addr = AW'(req_node_a) * AW'(LEVELS) + AW'(req_write_level);

	// level scan, one level per cycle on both read ports
	assign iss_ok    = iss_q <= {1'b0, h};
	assign rd_en     = cmd.scan && iss_ok;
	assign rd_addr_a = base_a_q + AW'(iss_q[LEVEL_W-1:0]);
	assign rd_addr_b = base_b_q + AW'(iss_q[LEVEL_W-1:0]);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= ID_BITS'(req_ancestor_id);
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_a_q <= AW'(req_node_a) * AW'(LEVELS);
			base_b_q <= AW'(req_node_b) * AW'(LEVELS);
			a_oob_q  <= !(32'(req_node_a) < 32'(MAX_NODES));
			b_oob_q  <= !(32'(req_node_b) < 32'(MAX_NODES));
		end
		if (cmd.scan) begin
			cmp_lvl_q <= iss_q[LEVEL_W-1:0];
		end
		if (cmd.scan && stat.hit) begin
			lvl_q <= cmp_lvl_q;
			id_q  <= ANC_W'(ea);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q   <= '0;
			cmp_v_q <= 1'b0;
		end else if (cmd.load) begin
			iss_q   <= '0;
			cmp_v_q <= 1'b0;
		end else if (cmd.scan) begin
			cmp_v_q <= iss_ok;
			if (iss_ok) begin
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	// out of range nodes read as zero
	assign ea = a_oob_q ? '0 : rd_a_q;
	assign eb = b_oob_q ? '0 : rd_b_q;

	assign stat.hit = cmp_v_q && ((cmp_lvl_q == h) || (ea == eb));

	// distance = gamma * (2^(L+2) - 4)
	assign g_full    = FULL_W'(gamma_q);
	assign dist_full = (g_full << ({1'b0, lvl_q} + 6'd2)) - (g_full << 2);
	assign dist_sat  = (|dist_full[FULL_W-1:DIST_W]) ? '1 : dist_full[DIST_W-1:0];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			lca_level_q     <= lvl_q;
			lca_id_q        <= id_q;
			tree_distance_q <= dist_sat;
		end
	end

	assign stat.out_full = rsp_valid_q && !rsp_ready;

	assign rsp_valid     = rsp_valid_q;
	assign lca_level     = lca_level_q;
	assign lca_id        = lca_id_q;
	assign tree_distance = tree_distance_q;

endmodule
`default_nettype wire

@@ design/hst_lca_distance_query.sv @@
// channel  direction  handshake     payload
// req      sink       valid/ready   kind, node_a, node_b, write_level, ancestor_id
// rsp      source     valid/ready   lca_level, lca_id, tree_distance
// cfg      sink       cfg_we        cfg_idx, cfg_data
//
// a write item gives no result
// a query finds level m, at most the tree height (20 max by default)
// a query runs a level scan: one level per cycle on the two table read ports
// async reset clears control and config, the ancestor table is not cleared
// a query waits in its last step while the result register is still full
`default_nettype none
`include "hst_lca_distance_query_macros.svh"
module hst_lca_distance_query import hld_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int LEVELS    = LEVELS_DEF,
	parameter int ID_BITS   = ID_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	hld_req_if.sink                    req,
	hld_rsp_if.source                  rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t   cmd;
	stat_t  stat;
	state_t state;
	logic   req_ready;

	hld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd),
		.state     (state)
	);

	assign req.ready = req_ready;

	hld_dp #(
		.MAX_NODES (MAX_NODES),
		.LEVELS    (LEVELS),
		.ID_BITS   (ID_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_node_a      (req.node_a),
		.req_node_b      (req.node_b),
		.req_write_level (req.write_level),
		.req_ancestor_id (req.ancestor_id),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.lca_level       (rsp.lca_level),
		.lca_id          (rsp.lca_id),
		.tree_distance   (rsp.tree_distance)
	);

	`HLD_ASSERT_IMPL(a_rsp_from_dist, $rose(rsp.valid), $past(state == ST_DIST))
	`HLD_ASSERT_IMPL(a_level_range, rsp.valid, rsp.lca_level <= LEVEL_W'(LEVELS - 1))
	`HLD_ASSERT_IMPL(a_level0_dist, rsp.valid && (rsp.lca_level == '0), rsp.tree_distance == '0)
	`HLD_ASSERT_NEXT(a_write_idle, req.valid && req.ready && (req.kind == KIND_WRITE), state == ST_IDLE)

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import hld_pkg::*;

	localparam logic [63:0] DIST_SAT = (64'd1 << DIST_W) - 64'd1;

	typedef struct packed {
		logic               kind;
		logic [NODE_W-1:0]  node_a;
		logic [NODE_W-1:0]  node_b;
		logic [LEVEL_W-1:0] write_level;
		logic [ANC_W-1:0]   ancestor_id;
	} hst_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] lca_level;
		logic [ANC_W-1:0]   lca_id;
		logic [DIST_W-1:0]  tree_distance;
	} lca_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	hld_req_if req_ch();
	hld_rsp_if rsp_ch();

	hst_lca_distance_query i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [ANC_W-1:0]   anc_model [MAX_NODES_DEF][LEVELS_DEF];
	logic [LEVEL_W-1:0] height_cfg = '0;
	logic [GAMMA_W-1:0] gamma_cfg  = GAMMA_RESET;
	lca_result_t        lca_expected [$];

	// stimulus state
	hst_item_t          pending_items [$];
	logic [ANC_W-1:0]   path_of [MAX_NODES_DEF];
	logic [ANC_W-1:0]   salt [LEVELS_DEF];
	bit                 is_built [MAX_NODES_DEF];
	int                 built [$];
	int                 src_idle_pct = 0;
	int                 dst_idle_pct = 0;

	int n_accepted = 0;
	int n_results  = 0;
	int n_errors   = 0;
	int n_builds   = 0;
	int n_settings = 0;

	function automatic lca_result_t lca_lookup(input logic [NODE_W-1:0] a,
		input logic [NODE_W-1:0] b);
		lca_result_t r;
		int          h;
		int          lvl;
		logic [63:0] d;
		h = (height_cfg > LEVELS_DEF - 1) ? LEVELS_DEF - 1 : int'(height_cfg);
		lvl = h;
		r.lca_id = anc_model[a][h];
		for (int i = 0; i < h; i++) begin
			if (anc_model[a][i] == anc_model[b][i]) begin
				lvl = i;
				r.lca_id = anc_model[a][i];
				break;
			end
		end
		d = ((64'd1 << (lvl + 1)) - 64'd2) * 64'd2 * 64'(gamma_cfg);
		if (d > DIST_SAT)
			d = DIST_SAT;
		r.lca_level = lvl[LEVEL_W-1:0];
		r.tree_distance = d[DIST_W-1:0];
		return r;
	endfunction

	function automatic logic [ANC_W-1:0] tree_id(input int node, input int lvl);
		return (path_of[node] >> lvl) + salt[lvl];
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin : req_driver
		hst_item_t nxt;
		int        src_gap;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= KIND_WRITE;
			req_ch.node_a <= '0;
			req_ch.node_b <= '0;
			req_ch.write_level <= '0;
			req_ch.ancestor_id <= '0;
			src_gap = 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (src_gap > 0) begin
				src_gap = src_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_items.size() != 0 && src_idle_pct > 0 &&
				$urandom_range(99) < src_idle_pct) begin
				src_gap = $urandom_range(15);
				req_ch.valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				nxt = pending_items.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= nxt.kind;
				req_ch.node_a <= nxt.node_a;
				req_ch.node_b <= nxt.node_b;
				req_ch.write_level <= nxt.write_level;
				req_ch.ancestor_id <= nxt.ancestor_id;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result side ready, with one long hold-off
	always @(posedge clk or negedge arst_n) begin : rsp_stall
		int  dst_gap;
		int  hold_left;
		bit  hold_done;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			dst_gap = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else if (!hold_done && n_results >= 200) begin
			hold_done = 1'b1;
			hold_left = 400;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (dst_gap > 0) begin
			dst_gap = dst_gap - 1;
			rsp_ch.ready <= 1'b0;
		end else if (dst_idle_pct > 0 && $urandom_range(99) < dst_idle_pct) begin
			dst_gap = $urandom_range(15);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// result check, then prediction of the item accepted at this edge
	always @(posedge clk) begin : lca_check
		lca_result_t exp_r;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results <= n_results + 1;
				if (lca_expected.size() == 0) begin
					$display("%0t unexpected result: level %0d id %0h dist %0h", $time,
						rsp_ch.lca_level, rsp_ch.lca_id, rsp_ch.tree_distance);
					n_errors++;
				end else begin
					exp_r = lca_expected.pop_front();
					if (rsp_ch.lca_level !== exp_r.lca_level) begin
						$display("%0t lca_level mismatch: expected %0d actual %0d", $time,
							exp_r.lca_level, rsp_ch.lca_level);
						n_errors++;
					end
					if (rsp_ch.lca_id !== exp_r.lca_id) begin
						$display("%0t lca_id mismatch: expected %0h actual %0h", $time,
							exp_r.lca_id, rsp_ch.lca_id);
						n_errors++;
					end
					if (rsp_ch.tree_distance !== exp_r.tree_distance) begin
						$display("%0t tree_distance mismatch: expected %0h actual %0h",
							$time, exp_r.tree_distance, rsp_ch.tree_distance);
						n_errors++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				n_accepted <= n_accepted + 1;
				if (req_ch.kind == KIND_WRITE) begin
					if (req_ch.write_level < LEVELS_DEF)
						anc_model[req_ch.node_a][req_ch.write_level] = req_ch.ancestor_id;
				end else begin
					lca_expected = {lca_expected, lca_lookup(req_ch.node_a, req_ch.node_b)};
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TREE_HEIGHT)
			height_cfg = val[LEVEL_W-1:0];
		else
			gamma_cfg = val[GAMMA_W-1:0];
		n_settings++;
	endtask

	task automatic settle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() != 0 || req_ch.valid || lca_expected.size() != 0);
		repeat (32) @(posedge clk);
	endtask

	task automatic start_phase(input int src_pct, input int dst_pct);
		@(posedge clk);
		#1;
		src_idle_pct = src_pct;
		dst_idle_pct = dst_pct;
	endtask

	function automatic int pick_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 10;
			default: return 30;
		endcase
	endfunction

	task automatic push_write(input int node, input int lvl, input logic [ANC_W-1:0] id);
		hst_item_t it;
		it.kind = KIND_WRITE;
		it.node_a = node[NODE_W-1:0];
		it.node_b = NODE_W'($urandom);
		it.write_level = lvl[LEVEL_W-1:0];
		it.ancestor_id = id;
		pending_items = {pending_items, it};
	endtask

	task automatic push_query(input int a, input int b);
		hst_item_t it;
		it.kind = KIND_QUERY;
		it.node_a = a[NODE_W-1:0];
		it.node_b = b[NODE_W-1:0];
		it.write_level = LEVEL_W'($urandom);
		it.ancestor_id = ANC_W'($urandom);
		pending_items = {pending_items, it};
	endtask

	// writes every level of one node, levels in rotated order
	task automatic build_tree(input int node, input logic [ANC_W-1:0] path);
		int start;
		int lvl;
		path_of[node] = path;
		start = $urandom_range(LEVELS_DEF - 1);
		for (int i = 0; i < LEVELS_DEF; i++) begin
			lvl = (start + i) % LEVELS_DEF;
			push_write(node, lvl, tree_id(node, lvl));
		end
		if (!is_built[node]) begin
			is_built[node] = 1'b1;
			built = {built, node};
		end
		n_builds++;
	endtask

	task automatic gen_random(input int target);
		int n;
		int r;
		int node;
		int base;
		int a;
		int lvl;
		logic [ANC_W-1:0] mask;
		n = 0;
		while (n < target) begin
			r = $urandom_range(99);
			if (r < 8) begin
				node = $urandom_range(MAX_NODES_DEF - 1);
				base = built[$urandom_range(built.size() - 1)];
				mask = (20'h1 << $urandom_range(ANC_W)) - 20'h1;
				build_tree(node, path_of[base] ^ (ANC_W'($urandom) & mask));
				n += LEVELS_DEF;
			end else if (r < 68) begin
				a = built[$urandom_range(built.size() - 1)];
				if ($urandom_range(9) == 0)
					push_query(a, a);
				else
					push_query(a, built[$urandom_range(built.size() - 1)]);
				n++;
			end else if (r < 83) begin
				node = built[$urandom_range(built.size() - 1)];
				lvl = $urandom_range(LEVELS_DEF - 1);
				if ($urandom_range(2) == 0)
					push_write(node, lvl, ANC_W'($urandom));
				else
					push_write(node, lvl, tree_id(node, lvl));
				n++;
			end else if (r < 90) begin
				push_write($urandom_range(MAX_NODES_DEF - 1),
					$urandom_range(LEVELS_DEF, 31), ANC_W'($urandom));
			end else begin
				push_write($urandom_range(MAX_NODES_DEF - 1),
					$urandom_range(LEVELS_DEF - 1), ANC_W'($urandom));
				n++;
			end
		end
	endtask

	initial begin
		#10_000_000;
		$display("timeout: %0d items accepted, %0d results", n_accepted, n_results);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		logic [LEVEL_W-1:0] h_sel;
		logic [GAMMA_W-1:0] g_sel;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_TREE_HEIGHT;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_WRITE;
		req_ch.node_a = '0;
		req_ch.node_b = '0;
		req_ch.write_level = '0;
		req_ch.ancestor_id = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < LEVELS_DEF; i++)
			salt[i] = ANC_W'($urandom);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// a few trees, then directed queries at the extremes
		write_reg(CFG_TREE_HEIGHT, 20);
		write_reg(CFG_GAMMA, 24'hFFFFFF);
		start_phase(20, 20);
		build_tree(0, 20'h00000);
		build_tree(1023, 20'hFFFFF);
		build_tree(10'h155, ANC_W'($urandom));
		build_tree(10'h2AA, path_of[10'h155] ^ 20'h1);
		build_tree($urandom_range(1, 1022), ANC_W'($urandom));
		push_query(0, 0);
		push_query(0, 1023);
		push_query(1023, 0);
		push_query(10'h155, 10'h2AA);
		push_query(10'h2AA, 10'h155);
		push_query(10'h155, 0);
		push_query(1023, 10'h2AA);
		// writes to levels past the table are dropped
		push_write(0, LEVELS_DEF, 20'hFFFFF);
		push_write(1023, 31, 20'h00000);
		push_query(0, 1023);
		push_write(10'h2AA, 0, tree_id(10'h155, 0));
		push_query(10'h2AA, 10'h155);
		settle();

		write_reg(CFG_TREE_HEIGHT, 0);
		write_reg(CFG_GAMMA, 24'h000000);
		start_phase(20, 20);
		push_query(0, 1023);
		push_query(10'h155, 10'h155);
		settle();

		// height above the table saturates
		write_reg(CFG_TREE_HEIGHT, 31);
		write_reg(CFG_GAMMA, 24'h000001);
		start_phase(0, 0);
		push_query(0, 1023);
		push_query(10'h2AA, 10'h155);
		push_query(1023, 1023);
		settle();

		write_reg(CFG_TREE_HEIGHT, 1);
		write_reg(CFG_GAMMA, GAMMA_RESET);
		start_phase(10, 10);
		push_query(10'h155, 10'h2AA);
		push_query(0, 10'h155);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(4))
				0: h_sel = 0;
				1: h_sel = 20;
				2: h_sel = 31;
				default: h_sel = LEVEL_W'($urandom_range(20));
			endcase
			case ($urandom_range(3))
				0: g_sel = 24'h000000;
				1: g_sel = 24'hFFFFFF;
				default: g_sel = GAMMA_W'($urandom);
			endcase
			write_reg(CFG_TREE_HEIGHT, CFG_DATA_W'(h_sel));
			write_reg(CFG_GAMMA, CFG_DATA_W'(g_sel));
			start_phase(pick_pct(), pick_pct());
			gen_random(160);
			settle();
		end

		// closing stretch with no idling
		write_reg(CFG_TREE_HEIGHT, 20);
		write_reg(CFG_GAMMA, CFG_DATA_W'($urandom));
		start_phase(0, 0);
		gen_random(150);
		settle();

		$display("run covered %0d items and %0d query results over %0d register writes",
			n_accepted, n_results, n_settings);
		$display("%0d tree builds, height and gamma swept through both extremes",
			n_builds);
		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ hst_lca_distance_query.f @@
+incdir+design
design/hld_pkg.sv
design/hld_if.sv
design/hld_ctrl.sv
design/hld_dp.sv
design/hst_lca_distance_query.sv
verif/testbench.sv
